@@ rtl/slab_object_allocator_unit_assert.svh @@
// Assertion macros shared by the slab object allocator checkers.
// Holds only macro definitions; no other file is needed.
`ifndef SLAB_OBJECT_ALLOCATOR_UNIT_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/soa_pkg.sv @@
// Package for the slab object allocator: geometry constants, codes,
// controller states and the command and status bundles. No dependencies.
package soa_pkg;

   localparam int POOL_PAGES   = 16;
   localparam int PAGE_W       = 4;
   localparam int PAGE_BYTES   = 4096;
   localparam int OFF_W        = 12;
   localparam int SIZE_CLASSES = 8;
   localparam int CLASS_W      = 3;
   localparam int CLASS_SH     = 5;
   localparam int OBJ_HEADER   = 9;
   localparam int PAGE_HEADER  = 20;
   localparam int MAX_SLOTS    = 512;
   localparam int SLOT_W       = 9;
   localparam int CNT_W        = 10;
   localparam int SIZE_W       = 12;
   localparam int STRIDE_W     = 13;
   localparam int ADDR_W       = 16;
   localparam int PTR_W        = 5;
   localparam int MEM_AW       = PAGE_W + SLOT_W;
   localparam int MEM_DEPTH    = POOL_PAGES * MAX_SLOTS;
   localparam int DIV_W        = 12;
   localparam int DIV_CNT_W    = 4;
   localparam int REQ_DATA_W   = 32;

   localparam logic [PTR_W-1:0] NIL_PAGE = PTR_W'(31);
   localparam logic [CNT_W-1:0] NIL_SLOT = CNT_W'(1023);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_PAGE  = 2'd1,
      ST_BAD_ADDR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      K_FILL,
      K_REFILL,
      K_RELEASE
   } kind_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_A_WALK,
      S_DIV,
      S_A_CLAIM,
      S_TAKE,
      S_POP,
      S_MARK,
      S_F_CHK,
      S_F_SLOT,
      S_F_TAKEN,
      S_U_START,
      S_U_FIRST,
      S_U_WALK,
      S_U_FIX,
      S_U_DONE,
      S_FIN
   } state_type;

   typedef struct packed {
      logic accept;
      logic walk_step;
      logic div_start;
      logic div_free;
      logic set_class;
      logic claim;
      logic err_no_page;
      logic err_bad_addr;
      logic take_fresh;
      logic take_read;
      logic pop;
      logic mark;
      logic f_read;
      logic commit;
      logic u_start;
      logic u_head;
      logic u_walk;
      logic u_found;
      logic u_fix;
      logic ulist_full;
      logic push_full;
      logic push_part;
      logic rel_page;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic in_op;
      logic is_free;
      logic cur_nil;
      logic cur_match;
      logic div_busy;
      logic num_zero;
      logic no_free;
      logic sh_nil;
      logic fc_one;
      logic in_use;
      logic off_small;
      logic rem_nz;
      logic q_ge_total;
      logic taken_ok;
      logic fc_zero;
      logic fc_next_full;
      logic fc_full;
      logic cur_is_p;
      logic link_is_p;
      logic out_free;
   } sts_type;

   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-CLASS_SH-1:0] q;
      q = size[SIZE_W-1:CLASS_SH];
      if (q >= (SIZE_W-CLASS_SH)'(SIZE_CLASSES - 1)) begin
         return CLASS_W'(SIZE_CLASSES - 1);
      end
      return q[CLASS_W-1:0];
   endfunction

endpackage

@@ rtl/slab_object_allocator_unit.sv @@
// Slab object allocator: one request in, one response out per request.
// An allocation walks its class chain, and when no page matches it sizes a fresh page in the
// divider and claims it; it takes an untouched or a freed slot, and a page made full moves chains.
// A free checks the page, divides the offset in the 12-step divider and may move the page,
// with two moves when a full page goes back to partly free and is released at once.
// One request is in flight at a time; the response register frees the input side.
// Reset is synchronous and clears page occupancy, chain heads and the response valid.
module slab_object_allocator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [soa_pkg::REQ_DATA_W-1:0]   req_tdata,  // size[11:0], addr[27:12]
   input  logic                             req_tuser,  // op[0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [soa_pkg::ADDR_W-1:0]       rsp_tdata,  // obj_addr[15:0]
   output logic [1:0]                       rsp_tuser   // status[1:0]
);
   import soa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   soa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   soa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/soa_div.sv @@
// Restoring divider, one quotient bit per cycle, for slot arithmetic.
// Depends on soa_pkg.
module soa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [soa_pkg::DIV_W-1:0]     dividend,
   input  logic [soa_pkg::STRIDE_W-1:0]  divisor,
   output logic                          busy,
   output logic [soa_pkg::DIV_W-1:0]     quot,
   output logic [soa_pkg::STRIDE_W-1:0]  rem
);
   import soa_pkg::*;

   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_CNT_W-1:0] count_in;
   logic [STRIDE_W-1:0]  rem_ff;
   logic [DIV_W-1:0]     dq_ff;
   logic [STRIDE_W-1:0]  dvs_ff;
   logic [STRIDE_W:0]    trial;
   logic [STRIDE_W:0]    diff;
   logic                 ge;

   assign busy  = (count_ff != '0);
   assign trial = {rem_ff, dq_ff[DIV_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};
   assign quot  = dq_ff;
   assign rem   = rem_ff;

   always_comb begin
      count_in = count_ff;
      if (start) begin
         count_in = DIV_CNT_W'(DIV_W);
      end else if (busy) begin
         count_in = count_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         dvs_ff <= divisor;
      end else if (busy) begin
         rem_ff <= ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
         dq_ff  <= {dq_ff[DIV_W-2:0], ge};
      end
   end

endmodule

@@ rtl/soa_dp.sv @@
// Datapath of the slab object allocator: page tables, chain heads, slot
// memories, divider and result register. Depends on soa_pkg and soa_div.
module soa_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  soa_pkg::cmd_type                 cmd,
   output soa_pkg::sts_type                 sts,
   input  logic [soa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [soa_pkg::ADDR_W-1:0]       rsp_tdata,
   output logic [1:0]                       rsp_tuser
);
   import soa_pkg::*;

   logic [POOL_PAGES-1:0] in_use_ff;
   logic [SIZE_W-1:0]     obj_size_ff [POOL_PAGES];
   logic [CNT_W-1:0]      total_ff    [POOL_PAGES];
   logic [CNT_W-1:0]      fc_ff       [POOL_PAGES];
   logic [CNT_W-1:0]      fresh_ff    [POOL_PAGES];
   logic [CNT_W-1:0]      sh_ff       [POOL_PAGES];
   logic [PTR_W-1:0]      link_ff     [POOL_PAGES];
   logic [PTR_W-1:0]      partial_ff  [SIZE_CLASSES];
   logic [PTR_W-1:0]      full_ff     [SIZE_CLASSES];

   logic [CNT_W-1:0]      slot_link_mem [MEM_DEPTH];
   logic                  taken_mem     [MEM_DEPTH];

   logic                  op_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [CLASS_W-1:0]    c_ff;
   logic [PAGE_W-1:0]     p_ff;
   logic [PTR_W-1:0]      cur_ff;
   logic [PAGE_W-1:0]     prev_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [ADDR_W-1:0]     prod_ff;
   logic [1:0]            res_status_ff;
   logic [CNT_W-1:0]      sl_rd_ff;
   logic                  taken_rd_ff;
   logic                  rsp_valid_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   logic [1:0]            rsp_status_ff;

   logic [SIZE_W-1:0]     in_size;
   logic [ADDR_W-1:0]     in_addr;
   logic [CLASS_W-1:0]    in_class;
   logic [PTR_W-1:0]      in_head;
   logic [SIZE_W-1:0]     pg_obj_size;
   logic [CNT_W-1:0]      pg_total;
   logic [CNT_W-1:0]      pg_fc;
   logic [CNT_W-1:0]      pg_fresh;
   logic [CNT_W-1:0]      pg_sh;
   logic [PTR_W-1:0]      link_cur;
   logic [PTR_W-1:0]      head_sel;
   logic [STRIDE_W-1:0]   alloc_stride;
   logic [STRIDE_W-1:0]   free_stride;
   logic [OFF_W-1:0]      off;
   logic [DIV_W-1:0]      div_dividend;
   logic [STRIDE_W-1:0]   div_divisor;
   logic                  div_busy;
   logic [DIV_W-1:0]      quot;
   logic [STRIDE_W-1:0]   rem;
   logic [CNT_W-1:0]      num;
   logic [PAGE_W-1:0]     free_idx;
   logic                  free_found;
   logic [21:0]           prod_full;
   logic [MEM_AW-1:0]     taken_waddr;
   logic                  taken_we;
   logic                  taken_wdata;

   assign in_size  = req_tdata[SIZE_W-1:0];
   assign in_addr  = req_tdata[SIZE_W+ADDR_W-1:SIZE_W];
   assign in_class = class_of(in_size);
   assign in_head  = partial_ff[in_class];

   assign pg_obj_size = obj_size_ff[p_ff];
   assign pg_total    = total_ff[p_ff];
   assign pg_fc       = fc_ff[p_ff];
   assign pg_fresh    = fresh_ff[p_ff];
   assign pg_sh       = sh_ff[p_ff];
   assign link_cur    = link_ff[cur_ff[PAGE_W-1:0]];
   assign head_sel    = cmd.ulist_full ? full_ff[c_ff] : partial_ff[c_ff];

   assign alloc_stride = {1'b0, size_ff} + STRIDE_W'(OBJ_HEADER);
   assign free_stride  = {1'b0, pg_obj_size} + STRIDE_W'(OBJ_HEADER);
   assign off          = addr_ff[OFF_W-1:0];

   assign div_dividend = cmd.div_free ? off - DIV_W'(PAGE_HEADER + OBJ_HEADER)
                                      : DIV_W'(PAGE_BYTES - PAGE_HEADER);
   assign div_divisor  = cmd.div_free ? free_stride : alloc_stride;
   assign num = (quot > DIV_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : quot[CNT_W-1:0];
   assign prod_full = slot_ff * alloc_stride;

   soa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quot     (quot),
      .rem      (rem)
   );

   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = POOL_PAGES - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_idx   = PAGE_W'(i);
            free_found = 1'b1;
         end
      end
   end

   always_comb begin
      sts.in_op        = req_tuser;
      sts.is_free      = op_ff;
      sts.cur_nil      = (cur_ff == NIL_PAGE);
      sts.cur_match    = (pg_obj_size == size_ff);
      sts.div_busy     = div_busy;
      sts.num_zero     = (num == '0);
      sts.no_free      = !free_found;
      sts.sh_nil       = (pg_sh == NIL_SLOT);
      sts.fc_one       = (pg_fc == CNT_W'(1));
      sts.in_use       = in_use_ff[p_ff];
      sts.off_small    = (off < OFF_W'(PAGE_HEADER + OBJ_HEADER));
      sts.rem_nz       = (rem != '0);
      sts.q_ge_total   = (quot >= DIV_W'(pg_total));
      sts.taken_ok     = taken_rd_ff && ({1'b0, slot_ff} < pg_fresh);
      sts.fc_zero      = (pg_fc == '0);
      sts.fc_next_full = ((pg_fc + CNT_W'(1)) == pg_total);
      sts.fc_full      = (pg_fc == pg_total);
      sts.cur_is_p     = (cur_ff == {1'b0, p_ff});
      sts.link_is_p    = (link_cur == {1'b0, p_ff});
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         partial_ff   <= '{default: NIL_PAGE};
         full_ff      <= '{default: NIL_PAGE};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.claim) begin
            in_use_ff[free_idx] <= 1'b1;
            partial_ff[c_ff]    <= {1'b0, free_idx};
         end
         if (cmd.rel_page) begin
            in_use_ff[p_ff] <= 1'b0;
         end
         if (cmd.u_head) begin
            if (cmd.ulist_full) begin
               full_ff[c_ff] <= link_cur;
            end else begin
               partial_ff[c_ff] <= link_cur;
            end
         end
         if (cmd.push_full) begin
            full_ff[c_ff] <= {1'b0, p_ff};
         end
         if (cmd.push_part) begin
            partial_ff[c_ff] <= {1'b0, p_ff};
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff         <= req_tuser;
         size_ff       <= in_size;
         addr_ff       <= in_addr;
         c_ff          <= in_class;
         cur_ff        <= in_head;
         p_ff          <= (req_tuser == OP_FREE) ? in_addr[ADDR_W-1:OFF_W]
                                                 : in_head[PAGE_W-1:0];
         res_status_ff <= ST_OK;
      end
      if (cmd.walk_step) begin
         cur_ff <= link_cur;
         p_ff   <= link_cur[PAGE_W-1:0];
      end
      if (cmd.set_class) begin
         c_ff <= class_of(pg_obj_size);
      end
      if (cmd.claim) begin
         obj_size_ff[free_idx] <= size_ff;
         total_ff[free_idx]    <= num;
         fc_ff[free_idx]       <= num;
         fresh_ff[free_idx]    <= '0;
         sh_ff[free_idx]       <= NIL_SLOT;
         link_ff[free_idx]     <= partial_ff[c_ff];
         p_ff                  <= free_idx;
      end
      if (cmd.err_no_page) begin
         res_status_ff <= ST_NO_PAGE;
      end
      if (cmd.err_bad_addr) begin
         res_status_ff <= ST_BAD_ADDR;
      end
      if (cmd.take_fresh) begin
         slot_ff        <= pg_fresh[SLOT_W-1:0];
         fresh_ff[p_ff] <= pg_fresh + CNT_W'(1);
      end
      if (cmd.take_read) begin
         slot_ff <= pg_sh[SLOT_W-1:0];
      end
      if (cmd.pop) begin
         sh_ff[p_ff] <= sl_rd_ff;
      end
      if (cmd.mark) begin
         fc_ff[p_ff] <= pg_fc - CNT_W'(1);
         prod_ff     <= prod_full[ADDR_W-1:0];
      end
      if (cmd.f_read) begin
         slot_ff <= quot[SLOT_W-1:0];
      end
      if (cmd.commit) begin
         sh_ff[p_ff] <= {1'b0, slot_ff};
         fc_ff[p_ff] <= pg_fc + CNT_W'(1);
      end
      if (cmd.u_start) begin
         cur_ff <= head_sel;
      end
      if (cmd.u_walk) begin
         cur_ff <= link_cur;
      end
      if (cmd.u_found) begin
         prev_ff <= cur_ff[PAGE_W-1:0];
         cur_ff  <= {1'b0, p_ff};
      end
      if (cmd.u_fix) begin
         link_ff[prev_ff] <= link_cur;
      end
      if (cmd.push_full) begin
         link_ff[p_ff] <= full_ff[c_ff];
      end
      if (cmd.push_part) begin
         link_ff[p_ff] <= partial_ff[c_ff];
      end
      if (cmd.finish) begin
         rsp_status_ff <= res_status_ff;
         if (op_ff == OP_ALLOC && res_status_ff == ST_OK) begin
            rsp_addr_ff <= {p_ff, {OFF_W{1'b0}}}
                         + ADDR_W'(PAGE_HEADER + OBJ_HEADER) + prod_ff;
         end else begin
            rsp_addr_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         slot_link_mem[{p_ff, slot_ff}] <= pg_sh;
      end
      sl_rd_ff <= slot_link_mem[{p_ff, pg_sh[SLOT_W-1:0]}];
   end

   assign taken_we    = cmd.mark || cmd.commit;
   assign taken_wdata = cmd.mark;
   assign taken_waddr = {p_ff, slot_ff};

   always_ff @(posedge clock) begin
      if (taken_we) begin
         taken_mem[taken_waddr] <= taken_wdata;
      end
      taken_rd_ff <= taken_mem[{p_ff, quot[SLOT_W-1:0]}];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ rtl/soa_ctrl.sv @@
// Controller of the slab object allocator: sequences chain walks, the
// divider, slot handout and chain moves. Depends on soa_pkg.
module soa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  soa_pkg::sts_type  sts,
   output soa_pkg::cmd_type  cmd
);
   import soa_pkg::*;

   state_type state_ff;
   state_type state_in;
   kind_type  kind_ff;
   kind_type  kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= K_FILL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (sts.in_op == OP_FREE) ? S_F_CHK : S_A_WALK;
            end
         end
         S_A_WALK: begin
            if (sts.cur_nil) begin
               state_in = S_DIV;
            end else if (sts.cur_match) begin
               state_in = S_TAKE;
            end
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = sts.is_free ? S_F_SLOT : S_A_CLAIM;
            end
         end
         S_A_CLAIM: begin
            state_in = (sts.num_zero || sts.no_free) ? S_FIN : S_TAKE;
         end
         S_TAKE: begin
            state_in = sts.sh_nil ? S_MARK : S_POP;
         end
         S_POP: begin
            state_in = S_MARK;
         end
         S_MARK: begin
            if (sts.fc_one) begin
               kind_in  = K_FILL;
               state_in = S_U_START;
            end else begin
               state_in = S_FIN;
            end
         end
         S_F_CHK: begin
            state_in = (!sts.in_use || sts.off_small) ? S_FIN : S_DIV;
         end
         S_F_SLOT: begin
            state_in = (sts.rem_nz || sts.q_ge_total) ? S_FIN : S_F_TAKEN;
         end
         S_F_TAKEN: begin
            state_in = S_FIN;
            if (sts.taken_ok) begin
               if (sts.fc_zero) begin
                  kind_in  = K_REFILL;
                  state_in = S_U_START;
               end else if (sts.fc_next_full) begin
                  kind_in  = K_RELEASE;
                  state_in = S_U_START;
               end
            end
         end
         S_U_START: begin
            state_in = S_U_FIRST;
         end
         S_U_FIRST: begin
            state_in = sts.cur_is_p ? S_U_DONE : S_U_WALK;
         end
         S_U_WALK: begin
            if (sts.cur_nil) begin
               state_in = S_U_DONE;
            end else if (sts.link_is_p) begin
               state_in = S_U_FIX;
            end
         end
         S_U_FIX: begin
            state_in = S_U_DONE;
         end
         S_U_DONE: begin
            state_in = S_FIN;
            if (kind_ff == K_REFILL && sts.fc_full) begin
               kind_in  = K_RELEASE;
               state_in = S_U_START;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_tready     = 1'b0;
      cmd.ulist_full = (kind_ff == K_REFILL);
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_A_WALK: begin
            if (sts.cur_nil) begin
               cmd.div_start = 1'b1;
            end else if (!sts.cur_match) begin
               cmd.walk_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_free = sts.is_free;
         end
         S_A_CLAIM: begin
            if (sts.num_zero || sts.no_free) begin
               cmd.err_no_page = 1'b1;
            end else begin
               cmd.claim = 1'b1;
            end
         end
         S_TAKE: begin
            if (sts.sh_nil) begin
               cmd.take_fresh = 1'b1;
            end else begin
               cmd.take_read = 1'b1;
            end
         end
         S_POP: begin
            cmd.pop = 1'b1;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
         end
         S_F_CHK: begin
            if (!sts.in_use || sts.off_small) begin
               cmd.err_bad_addr = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_free  = 1'b1;
               cmd.set_class = 1'b1;
            end
         end
         S_F_SLOT: begin
            if (sts.rem_nz || sts.q_ge_total) begin
               cmd.err_bad_addr = 1'b1;
            end else begin
               cmd.f_read = 1'b1;
            end
         end
         S_F_TAKEN: begin
            if (sts.taken_ok) begin
               cmd.commit = 1'b1;
            end else begin
               cmd.err_bad_addr = 1'b1;
            end
         end
         S_U_START: begin
            cmd.u_start = 1'b1;
         end
         S_U_FIRST: begin
            cmd.u_head = sts.cur_is_p;
         end
         S_U_WALK: begin
            if (!sts.cur_nil) begin
               if (sts.link_is_p) begin
                  cmd.u_found = 1'b1;
               end else begin
                  cmd.u_walk = 1'b1;
               end
            end
         end
         S_U_FIX: begin
            cmd.u_fix = 1'b1;
         end
         S_U_DONE: begin
            case (kind_ff)
               K_FILL:    cmd.push_full = 1'b1;
               K_REFILL:  cmd.push_part = 1'b1;
               K_RELEASE: cmd.rel_page  = 1'b1;
               default:   cmd.rel_page  = 1'b0;
            endcase
         end
         S_FIN: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd.finish = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/soa_chk.sv @@
// Port checker for the slab object allocator, bound to the top level.
// Depends on soa_pkg and slab_object_allocator_unit_assert.svh.
`include "slab_object_allocator_unit_assert.svh"
module soa_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [soa_pkg::ADDR_W-1:0]  rsp_tdata,
   input logic [1:0]                  rsp_tuser
);
   import soa_pkg::*;

   `SOA_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid, rsp_tuser == ST_OK || rsp_tuser == ST_NO_PAGE || rsp_tuser == ST_BAD_ADDR, "Response status is not a defined code.")
   `SOA_ASSERT_IMP(a_err_addr_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata == '0, "Failed response carries a nonzero address.")
   `SOA_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "A second request was taken while one is in progress.")
   `SOA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "Response beat dropped before it was taken.")
   `SOA_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled response beat changed.")

endmodule

bind slab_object_allocator_unit soa_chk u_soa_chk (.*);
